### hdl/pct_pkg.sv
package pct_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int ID_BITS       = 6;
  localparam int MODE_BITS     = 3;
  localparam int STATUS_BITS   = 2;

  // Operation codes
  localparam logic [MODE_BITS-1:0] MODE_ADD     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_PROMOTE = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_GET_MAX = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_POP_MAX = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_IS_LIVE = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_GET     = 3'd5;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_DEAD  = 2'd3;

  localparam logic [PRIORITY_BITS-1:0] PRIO_TOP = '1;

  // One table slot as held in memory
  typedef struct packed {
    logic                     live;
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  payload;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic [STATUS_BITS-1:0]   status;
    logic [ID_BITS-1:0]       id;
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [PRIORITY_BITS-1:0] prio;
    logic                     live;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_WRAP,
    S_FINISH
  } state_t;

endpackage

### hdl/pct_if.sv
interface pct_req_if;
  logic                               valid;
  logic                               ready;
  logic [pct_pkg::MODE_BITS-1:0]      mode;
  logic [pct_pkg::ID_BITS-1:0]        entry_id;
  logic [pct_pkg::PAYLOAD_BITS-1:0]   payload_in;

  modport source(output valid, mode, entry_id, payload_in, input ready);
  modport sink(input valid, mode, entry_id, payload_in, output ready);
endinterface

interface pct_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [pct_pkg::STATUS_BITS-1:0]    status;
  logic [pct_pkg::ID_BITS-1:0]        id_out;
  logic [pct_pkg::PAYLOAD_BITS-1:0]   payload_out;
  logic [pct_pkg::PRIORITY_BITS-1:0]  priority_out;
  logic                               is_live;

  modport source(output valid, status, id_out, payload_out, priority_out, is_live,
                 input ready);
  modport sink(input valid, status, id_out, payload_out, priority_out, is_live,
               output ready);
endinterface

### hdl/pct_ram.sv
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/priority_collection_table_top.sv
// Priority collection table: up to CAPACITY entries, each a payload word and
// a priority, kept in one synchronous RAM (one write and one read port).
//
// Channels: req carries mode, entry_id and payload_in; rsp returns exactly
// one item per request (status, id_out, payload_out, priority_out, is_live).
// Both use valid/ready; an item moves when valid and ready are both high.
//
// Path from request acceptance to rsp.valid, by mode:
//   add, empty get/pop max, unused modes   finish, output register
//   promote, is live, get                  lookup (one RAM read), finish, output register
//   get max, pop max                        scan over ids handed out, wrap, finish, output register
// Get/pop max scans every slot ever allocated, one RAM read per cycle, and
// that scan bounds the rate of those modes. One request is worked on at a
// time; the FSM returns to idle, where the next is taken, as the previous
// result moves to the output register.
//
// Reset clears the FSM, the id counter and the output valid. Slot contents
// need no clearing: a slot counts as live only below the id counter.
// A stalled rsp holds its item; the next request is still taken and worked,
// then waits in the finish state until the output register frees up.
module priority_collection_table_top #(
  parameter int CAPACITY = pct_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pct_req_if.sink   req,
  pct_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  // Width that holds both an external id and the id counter
  localparam int CW = (AW + 1 > pct_pkg::ID_BITS) ? AW + 1 : pct_pkg::ID_BITS;
  localparam logic [AW:0] FULL_COUNT = (AW + 1)'(CAPACITY);

  pct_pkg::state_t  state, state_next;

  logic [AW:0]      next_free;
  logic [pct_pkg::MODE_BITS-1:0] op_mode;
  logic [pct_pkg::ID_BITS-1:0]   op_id;

  logic [AW:0]      scan_idx;
  logic             scan_issue;
  logic             scan_done;
  logic             rd_vld;
  logic [AW-1:0]    rd_idx;

  logic             best_found;
  logic             best_take;
  logic [AW-1:0]    best_idx;
  logic [pct_pkg::PRIORITY_BITS-1:0] best_prio;
  logic [pct_pkg::PAYLOAD_BITS-1:0]  best_payload;

  pct_pkg::result_t res, res_next, out_res;
  logic             out_vld;

  logic             req_fire;
  logic             is_full;
  logic             id_ok;
  logic             out_load;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  pct_pkg::slot_t   ram_wslot;
  logic [AW-1:0]    ram_raddr;
  logic [pct_pkg::SLOT_BITS-1:0] ram_rdata;
  pct_pkg::slot_t   rslot;

  pct_ram #(
    .WIDTH(pct_pkg::SLOT_BITS),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wslot),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rslot      = pct_pkg::slot_t'(ram_rdata);
  assign req_fire   = req.valid && req.ready;
  assign is_full    = (next_free == FULL_COUNT);
  // Only slots below the id counter were ever written
  assign id_ok      = (CW'(op_id) < CW'(next_free)) && rslot.live;
  assign scan_done  = (scan_idx == next_free);
  assign scan_issue = (state == pct_pkg::S_SCAN) && !scan_done;
  // Ties go to the larger id: later slots win on equal priority
  assign best_take  = rd_vld && rslot.live && (!best_found || rslot.prio >= best_prio);
  assign out_load   = (state == pct_pkg::S_FINISH) && (!out_vld || rsp.ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pct_pkg::S_IDLE: begin
        if (req_fire) begin
          priority if (req.mode == pct_pkg::MODE_GET_MAX ||
                       req.mode == pct_pkg::MODE_POP_MAX) begin
            state_next = (next_free == '0) ? pct_pkg::S_FINISH : pct_pkg::S_SCAN;
          end else if (req.mode == pct_pkg::MODE_PROMOTE ||
                       req.mode == pct_pkg::MODE_IS_LIVE ||
                       req.mode == pct_pkg::MODE_GET) begin
            state_next = pct_pkg::S_LOOKUP;
          end else begin
            state_next = pct_pkg::S_FINISH;
          end
        end
      end
      pct_pkg::S_LOOKUP: state_next = pct_pkg::S_FINISH;
      pct_pkg::S_SCAN: begin
        // The last compare lands at this edge, ahead of the wrap-up
        if (scan_done) begin
          state_next = pct_pkg::S_WRAP;
        end
      end
      pct_pkg::S_WRAP:   state_next = pct_pkg::S_FINISH;
      pct_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = pct_pkg::S_IDLE;
        end
      end
      default: state_next = pct_pkg::S_IDLE;
    endcase
  end

  // Outputs: RAM access and result formation
  always_comb begin
    req.ready = (state == pct_pkg::S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = next_free[AW-1:0];
    ram_wslot = '0;
    ram_raddr = AW'(req.entry_id);
    res_next  = res;
    unique case (state)
      pct_pkg::S_IDLE: begin
        if (req_fire) begin
          res_next = '0;
          unique case (req.mode)
            pct_pkg::MODE_ADD: begin
              if (is_full) begin
                res_next.status = pct_pkg::ST_FULL;
              end else begin
                ram_we            = 1'b1;
                ram_wslot.live    = 1'b1;
                ram_wslot.payload = req.payload_in;
                res_next.id       = pct_pkg::ID_BITS'(next_free);
              end
            end
            pct_pkg::MODE_GET_MAX, pct_pkg::MODE_POP_MAX: begin
              if (next_free == '0) begin
                res_next.status = pct_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      pct_pkg::S_LOOKUP: begin
        res_next = '0;
        unique case (op_mode)
          pct_pkg::MODE_PROMOTE: begin
            if (!id_ok) begin
              res_next.status = pct_pkg::ST_DEAD;
            end else if (rslot.prio != pct_pkg::PRIO_TOP) begin
              ram_we         = 1'b1;
              ram_waddr      = AW'(op_id);
              ram_wslot      = rslot;
              ram_wslot.prio = rslot.prio + 1'b1;
            end
          end
          pct_pkg::MODE_IS_LIVE: res_next.live = id_ok;
          pct_pkg::MODE_GET: begin
            if (!id_ok) begin
              res_next.status = pct_pkg::ST_DEAD;
            end else begin
              res_next.payload = rslot.payload;
            end
          end
          default: ;
        endcase
      end
      pct_pkg::S_SCAN: ram_raddr = scan_idx[AW-1:0];
      pct_pkg::S_WRAP: begin
        res_next = '0;
        if (!best_found) begin
          res_next.status = pct_pkg::ST_EMPTY;
        end else begin
          res_next.id      = pct_pkg::ID_BITS'(best_idx);
          res_next.payload = best_payload;
          res_next.prio    = best_prio;
          // Retire the winner
          if (op_mode == pct_pkg::MODE_POP_MAX) begin
            ram_we            = 1'b1;
            ram_waddr         = best_idx;
            ram_wslot.live    = 1'b0;
            ram_wslot.prio    = best_prio;
            ram_wslot.payload = best_payload;
          end
        end
      end
      pct_pkg::S_FINISH: ;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pct_pkg::S_IDLE;
      next_free  <= '0;
      rd_vld     <= 1'b0;
      best_found <= 1'b0;
      out_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= scan_issue;
      if (req_fire && req.mode == pct_pkg::MODE_ADD && !is_full) begin
        next_free <= next_free + 1'b1;
      end
      if (req_fire) begin
        best_found <= 1'b0;
      end else if (best_take) begin
        best_found <= 1'b1;
      end
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    res    <= res_next;
    rd_idx <= scan_idx[AW-1:0];
    if (state == pct_pkg::S_IDLE) begin
      scan_idx <= '0;
    end else if (scan_issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (req_fire) begin
      op_mode <= req.mode;
      op_id   <= req.entry_id;
    end
    if (best_take) begin
      best_idx     <= rd_idx;
      best_prio    <= rslot.prio;
      best_payload <= rslot.payload;
    end
    if (out_load) begin
      out_res <= res;
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.status       = out_res.status;
  assign rsp.id_out       = out_res.id;
  assign rsp.payload_out  = out_res.payload;
  assign rsp.priority_out = out_res.prio;
  assign rsp.is_live      = out_res.live;

endmodule

### hdl/pct_checker.sv
module pct_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [pct_pkg::STATUS_BITS-1:0]    status,
  input logic [pct_pkg::ID_BITS-1:0]        id_out,
  input logic [pct_pkg::PAYLOAD_BITS-1:0]   payload_out,
  input logic [pct_pkg::PRIORITY_BITS-1:0]  priority_out,
  input logic                               is_live
);

  logic [1:0] inflight;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Count items taken whose result has not been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + {1'b0, req_fire} - {1'b0, rsp_fire};
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(status) && $stable(id_out) &&
      $stable(payload_out) && $stable(priority_out) && $stable(is_live))
    else $error("response changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> inflight != 2'd0)
    else $error("response without a request");

  a_one_waiting: assert property (@(posedge clk) disable iff (rst)
    req_fire |-> inflight != 2'd2)
    else $error("request taken with two results pending");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != pct_pkg::ST_OK |->
      payload_out == '0 && priority_out == '0 && !is_live)
    else $error("error response carries data");

endmodule

bind priority_collection_table_top pct_checker u_pct_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .id_out      (rsp.id_out),
  .payload_out (rsp.payload_out),
  .priority_out(rsp.priority_out),
  .is_live     (rsp.is_live)
);
